// ===== sv/chunked_file_stream_receiver_macros.svh =====
// Assertion macros for the chunked file stream receiver
`ifndef CHUNKED_FILE_STREAM_RECEIVER_MACROS_SVH
`define CHUNKED_FILE_STREAM_RECEIVER_MACROS_SVH
`ifndef ASSERT_OFF
`define CFSR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CFSR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CFSR_ASSERT(label, clk, rst_n, prop, msg)
`define CFSR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/cfsr_pkg.sv =====
// Shared types, constants and the CRC function of the chunked file stream receiver
`default_nettype none
package cfsr_pkg;
  localparam int unsigned CHUNK_LEN_WIDTH = 23;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] HARD_MAX = 32'd1 << (CHUNK_LEN_WIDTH - 1);

  localparam logic [1:0] REG_MAGIC = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_NAME_LEN = 2'd2;
  localparam logic [1:0] REG_CHUNK = 2'd3;

  localparam logic [2:0] K_NAME = 3'd0;
  localparam logic [2:0] K_PAYLOAD = 3'd1;
  localparam logic [2:0] K_ACK = 3'd2;
  localparam logic [2:0] K_DONE = 3'd3;
  localparam logic [2:0] K_ERROR = 3'd4;

  localparam logic [1:0] E_MAGIC = 2'd0;
  localparam logic [1:0] E_HDR = 2'd1;
  localparam logic [1:0] E_CHDR = 2'd2;
  localparam logic [1:0] E_CRC = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] ack_seq;
    logic        ack_ok;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // one classified byte: up to three results in order
  typedef struct packed {
    logic [1:0]  count;
    logic [2:0]  kind0;
    logic [7:0]  data_byte;
    logic [31:0] ack_seq;
    logic        ack_ok;
    logic        second_done;
    logic        third;
    logic        third_done;
    logic [1:0]  err_code;
  } work_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/cfsr_stream_if.sv =====
// Valid/ready stream interfaces of the receiver
`default_nettype none
interface cfsr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfsr_result_if;
  logic              valid;
  logic              ready;
  cfsr_pkg::result_t res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface
`default_nettype wire

// ===== sv/chunked_file_stream_receiver.sv =====
// Top level of the chunked file stream receiver
// Usage:
//  in_if carries received bytes (rx_byte); one transfer per valid&&ready cycle.
//  out_if carries results (kind, data_byte, ack_seq, ack_ok, error_code, last).
//  The front end parses and checks each byte in the cycle it is accepted and
//  pushes it, if it yields results, into a four-entry queue; the back end
//  expands it into one to three result transfers, the final one flagged by last.
//  Throughput: one byte per cycle while the queue has room; a byte that ends a
//  chunk yields two results (three when it also ends the file or fails its CRC),
//  so the output port sets the sustained rate.
//  Results enter the queue as their byte is accepted, behind older entries.
//  Stalls: when out ready stays low the queue fills and in ready drops.
//  Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are taken at once;
//  write only while idle.
//  Reset: the registers return to defaults, the parser restarts at the file
//  header and the queue empties. After an error or done the block stays quiet
//  (bytes are accepted, no results) until reset.
`default_nettype none
module chunked_file_stream_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  cfsr_byte_if.sink        in_if,
  cfsr_result_if.source    out_if
);
  cfsr_pkg::work_t work;
  logic space;

  assign in_if.ready = space;

  cfsr_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i(in_if.valid), .in_byte_i(in_if.rx_byte), .take_i(space),
    .work_o(work)
  );

  cfsr_back u_back (
    .clk_i, .rst_ni, .push_i(in_if.valid && space), .work_i(work), .space_o(space),
    .out_valid_o(out_if.valid), .out_res_o(out_if.res), .out_ready_i(out_if.ready)
  );
endmodule
`default_nettype wire

// ===== sv/cfsr_front.sv =====
// Front end: header parsing, checks, CRC and classification of each byte
`default_nettype none
module cfsr_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               take_i,
  output cfsr_pkg::work_t         work_o
);
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0, PH_NAME = 3'd1, PH_CHDR = 3'd2, PH_PAYLOAD = 3'd3, PH_QUIET = 3'd4
  } phase_e;
  localparam int unsigned LW = cfsr_pkg::CHUNK_LEN_WIDTH;

  phase_e phase_q;
  logic [4:0]  fcnt_q;
  logic [63:0] asm_q;
  logic [15:0] name_left_q;
  logic [63:0] total_q, done_q;
  logic [LW-1:0] limit_q, left_q;
  logic [31:0] next_seq_q, seq_q, crc_exp_q, crc_q;
  logic [1:0]  fault_q;
  logic [31:0] magic_q, version_q;
  logic [15:0] maxname_q;
  logic [22:0] maxchunk_q;
  logic        rem_small_q;

  logic [63:0] asm_n;
  logic [4:0]  fcnt_n;
  logic [31:0] w32, crc_n;
  logic [63:0] done_n;
  logic        ok;
  cfsr_pkg::work_t w;

  assign asm_n = {asm_q[55:0], in_byte_i};
  assign fcnt_n = fcnt_q + 5'd1;
  assign w32 = asm_n[31:0];
  assign crc_n = cfsr_pkg::crc_byte(crc_q, in_byte_i);
  assign done_n = done_q + 64'd1;
  assign ok = (crc_n ^ cfsr_pkg::CRC_ONES) == crc_exp_q;

  always_comb begin
    w = '0;
    w.data_byte = in_byte_i;
    w.ack_seq = seq_q;
    w.ack_ok = ok;
    case (phase_q)
      PH_HEADER: begin
        if (fcnt_n == 5'd24) begin
          if (fault_q[0]) begin
            w.count = 2'd1; w.kind0 = cfsr_pkg::K_ERROR; w.err_code = cfsr_pkg::E_MAGIC;
          end else if (fault_q[1] || w32 == 32'd0 || w32 > {9'd0, maxchunk_q}
                       || w32 > cfsr_pkg::HARD_MAX) begin
            w.count = 2'd1; w.kind0 = cfsr_pkg::K_ERROR; w.err_code = cfsr_pkg::E_HDR;
          end
        end
      end
      PH_NAME: begin
        w.count = 2'd1; w.kind0 = cfsr_pkg::K_NAME;
        if (name_left_q == 16'd1 && done_q >= total_q) begin
          w.count = 2'd2; w.second_done = 1'b1;
        end
      end
      PH_CHDR: begin
        if (fcnt_n == 5'd12 && fault_q != 2'd0) begin
          w.count = 2'd1; w.kind0 = cfsr_pkg::K_ERROR; w.err_code = cfsr_pkg::E_CHDR;
        end
      end
      PH_PAYLOAD: begin
        w.count = 2'd1; w.kind0 = cfsr_pkg::K_PAYLOAD;
        if (left_q == LW'(1)) begin
          w.count = 2'd2;
          if (!ok) begin
            w.count = 2'd3; w.third = 1'b1; w.err_code = cfsr_pkg::E_CRC;
          end else if (done_n >= total_q) begin
            w.count = 2'd3; w.third = 1'b1; w.third_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end
  assign work_o = w;

  logic acc;
  assign acc = in_valid_i && take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= 32'h53465431; version_q <= 32'd1;
      maxname_q <= 16'd1024; maxchunk_q <= 23'd4194304;
      phase_q <= PH_HEADER; fcnt_q <= '0; asm_q <= '0; name_left_q <= '0;
      total_q <= '0; done_q <= '0; limit_q <= '0; left_q <= '0;
      next_seq_q <= '0; seq_q <= '0; crc_exp_q <= '0; crc_q <= cfsr_pkg::CRC_ONES;
      fault_q <= '0; rem_small_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          cfsr_pkg::REG_MAGIC:    magic_q <= cfg_data_i;
          cfsr_pkg::REG_VERSION:  version_q <= cfg_data_i;
          cfsr_pkg::REG_NAME_LEN: maxname_q <= cfg_data_i[15:0];
          cfsr_pkg::REG_CHUNK:    maxchunk_q <= cfg_data_i[22:0];
          default: ;
        endcase
      end
      if (acc) begin
        case (phase_q)
          PH_HEADER: begin
            asm_q <= asm_n; fcnt_q <= (fcnt_n == 5'd24) ? 5'd0 : fcnt_n;
            case (fcnt_n)
              5'd4:  if (w32 != magic_q) fault_q[0] <= 1'b1;
              5'd8:  if (w32 != version_q) fault_q[0] <= 1'b1;
              5'd12: begin
                if (w32 == 32'd0 || w32 > {16'd0, maxname_q}) fault_q[1] <= 1'b1;
                name_left_q <= w32[15:0];
              end
              5'd20: total_q <= asm_n;
              5'd24: begin
                limit_q <= w32[LW-1:0]; fault_q <= '0;
                phase_q <= (w.count != 2'd0) ? PH_QUIET : PH_NAME;
              end
              default: ;
            endcase
          end
          PH_NAME: begin
            name_left_q <= name_left_q - 16'd1;
            if (name_left_q == 16'd1) begin
              phase_q <= w.second_done ? PH_QUIET : PH_CHDR;
              fcnt_q <= '0; fault_q <= '0;
            end
          end
          PH_CHDR: begin
            asm_q <= asm_n; fcnt_q <= (fcnt_n == 5'd12) ? 5'd0 : fcnt_n;
            // precompute remaining-size compare for the size field
            if (fcnt_n == 5'd4) begin
              seq_q <= w32;
              if (w32 != next_seq_q) fault_q[1] <= 1'b1;
              rem_small_q <= (total_q - done_q) < 64'h1_0000_0000;
            end
            if (fcnt_n == 5'd8) begin
              if (w32 == 32'd0 || {32'd0, w32} > {{(64-LW){1'b0}}, limit_q}
                  || (rem_small_q && w32 > total_q[31:0] - done_q[31:0]))
                fault_q[1] <= 1'b1;
              left_q <= w32[LW-1:0];
            end
            if (fcnt_n == 5'd12) begin
              crc_exp_q <= w32; fault_q <= '0;
              crc_q <= cfsr_pkg::CRC_ONES;
              phase_q <= (fault_q != 2'd0) ? PH_QUIET : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            crc_q <= crc_n; done_q <= done_n; left_q <= left_q - LW'(1);
            if (left_q == LW'(1)) begin
              if (ok) next_seq_q <= next_seq_q + 32'd1;
              phase_q <= w.third ? PH_QUIET : PH_CHDR;
              fcnt_q <= '0; fault_q <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/cfsr_back.sv =====
// Back end: queue of classified bytes and expansion into result transfers
`default_nettype none
`include "chunked_file_stream_receiver_macros.svh"
module cfsr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cfsr_pkg::work_t work_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  output cfsr_pkg::result_t    out_res_o,
  input  wire logic            out_ready_i
);
  localparam int unsigned PW = cfsr_pkg::QPTR_W;
  cfsr_pkg::work_t mem_q [cfsr_pkg::QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic [1:0]    sub_q;
  cfsr_pkg::work_t h;
  logic pop, fire, push;

  assign h = mem_q[rd_q];
  assign push = push_i && work_i.count != 2'd0;
  assign space_o = cnt_q < (PW+1)'(cfsr_pkg::QDEPTH);
  assign out_valid_o = cnt_q != '0;
  assign fire = out_valid_o && out_ready_i;
  assign pop = fire && (sub_q == h.count - 2'd1);

  always_comb begin
    out_res_o = '0;
    out_res_o.last = sub_q == h.count - 2'd1;
    case (sub_q)
      2'd0: begin
        out_res_o.kind = h.kind0;
        if (h.kind0 == cfsr_pkg::K_ERROR) out_res_o.error_code = h.err_code;
        else out_res_o.data_byte = h.data_byte;
      end
      2'd1: begin
        if (h.second_done) out_res_o.kind = cfsr_pkg::K_DONE;
        else begin
          out_res_o.kind = cfsr_pkg::K_ACK;
          out_res_o.ack_seq = h.ack_seq; out_res_o.ack_ok = h.ack_ok;
        end
      end
      default: begin
        if (h.third_done) out_res_o.kind = cfsr_pkg::K_DONE;
        else begin
          out_res_o.kind = cfsr_pkg::K_ERROR; out_res_o.error_code = h.err_code;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= work_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PW'(1);
      if (pop) rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
      if (pop) sub_q <= '0;
      else if (fire) sub_q <= sub_q + 2'd1;
    end
  end

  `CFSR_ASSERT(a_no_overflow, clk_i, rst_ni, push |-> space_o, "queue overflow")
  `CFSR_ASSERT(a_sub_range, clk_i, rst_ni, out_valid_o |-> sub_q < h.count, "bad sub index")
  `CFSR_ASSERT(a_last_pop, clk_i, rst_ni, fire |-> (out_res_o.last == pop), "last mismatch")
endmodule
`default_nettype wire

// ===== verif/chunked_file_stream_receiver_tb.sv =====
// Testbench for the chunked file stream receiver: predicts and checks every result of one file
`timescale 1ns / 100ps
`default_nettype none
module chunked_file_stream_receiver_tb;

  typedef enum logic [2:0] {
    ST_HEADER = 3'd0, ST_NAME = 3'd1, ST_CHDR = 3'd2, ST_PAYLOAD = 3'd3, ST_QUIET = 3'd4
  } parse_state_e;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) r = (r >> 1) ^ 32'hEDB88320;
      else r = r >> 1;
    end
    return r;
  endfunction

  class receiver_scoreboard;
    logic [31:0] magic_reg, version_reg;
    logic [15:0] name_max_reg;
    logic [22:0] chunk_max_reg;
    parse_state_e state;
    logic [4:0]  field_cnt;
    logic [63:0] shift_word;
    logic [15:0] name_left;
    logic [63:0] total_bytes, bytes_done;
    logic [22:0] chunk_limit, chunk_left;
    logic [31:0] next_seq, chunk_seq, crc_want, crc_run;
    logic [1:0]  fault;
    cfsr_pkg::result_t pending[$];
    int          errors;

    function new();
      magic_reg = 32'h53465431; version_reg = 32'd1;
      name_max_reg = 16'd1024; chunk_max_reg = 23'd4194304;
      state = ST_HEADER; field_cnt = '0; shift_word = '0; name_left = '0;
      total_bytes = '0; bytes_done = '0; chunk_limit = '0; chunk_left = '0;
      next_seq = '0; chunk_seq = '0; crc_want = '0; crc_run = '1; fault = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        cfsr_pkg::REG_MAGIC: magic_reg = v;
        cfsr_pkg::REG_VERSION: version_reg = v;
        cfsr_pkg::REG_NAME_LEN: name_max_reg = v[15:0];
        cfsr_pkg::REG_CHUNK: chunk_max_reg = v[22:0];
        default: ;
      endcase
    endfunction

    function void push(logic [2:0] k, logic [7:0] d, logic [31:0] s, logic ok, logic [1:0] c);
      cfsr_pkg::result_t r;
      r.kind = k; r.data_byte = d; r.ack_seq = s; r.ack_ok = ok; r.error_code = c; r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [31:0] w;
      int prev_count;
      logic ok;
      prev_count = pending.size();
      case (state)
        ST_HEADER: begin
          shift_word = {shift_word[55:0], b};
          field_cnt = field_cnt + 5'd1;
          w = shift_word[31:0];
          if (field_cnt == 5'd4) begin
            if (w != magic_reg) fault[0] = 1'b1;
          end else if (field_cnt == 5'd8) begin
            if (w != version_reg) fault[0] = 1'b1;
          end else if (field_cnt == 5'd12) begin
            if (w == 32'd0 || w > {16'd0, name_max_reg}) fault[1] = 1'b1;
            name_left = w[15:0];
          end else if (field_cnt == 5'd20) begin
            total_bytes = shift_word;
          end else if (field_cnt == 5'd24) begin
            if (w == 32'd0 || w > {9'd0, chunk_max_reg} || w > cfsr_pkg::HARD_MAX)
              fault[1] = 1'b1;
            chunk_limit = w[22:0];
            field_cnt = '0;
            if (fault[0]) begin
              push(cfsr_pkg::K_ERROR, '0, '0, '0, cfsr_pkg::E_MAGIC); state = ST_QUIET;
            end else if (fault[1]) begin
              push(cfsr_pkg::K_ERROR, '0, '0, '0, cfsr_pkg::E_HDR); state = ST_QUIET;
            end else state = ST_NAME;
            fault = '0;
          end
        end
        ST_NAME: begin
          push(cfsr_pkg::K_NAME, b, '0, '0, '0);
          name_left = name_left - 16'd1;
          if (name_left == 16'd0) begin
            if (bytes_done >= total_bytes) begin
              push(cfsr_pkg::K_DONE, '0, '0, '0, '0); state = ST_QUIET;
            end else begin
              state = ST_CHDR; field_cnt = '0; fault = '0;
            end
          end
        end
        ST_CHDR: begin
          shift_word = {shift_word[55:0], b};
          field_cnt = field_cnt + 5'd1;
          w = shift_word[31:0];
          if (field_cnt == 5'd4) begin
            chunk_seq = w;
            if (w != next_seq) fault[1] = 1'b1;
          end else if (field_cnt == 5'd8) begin
            if (w == 32'd0 || w > {9'd0, chunk_limit} || {32'd0, w} > total_bytes - bytes_done)
              fault[1] = 1'b1;
            chunk_left = w[22:0];
          end else if (field_cnt == 5'd12) begin
            crc_want = w;
            field_cnt = '0;
            if (fault != 2'd0) begin
              push(cfsr_pkg::K_ERROR, '0, '0, '0, cfsr_pkg::E_CHDR); state = ST_QUIET;
            end else begin
              crc_run = '1; state = ST_PAYLOAD;
            end
            fault = '0;
          end
        end
        ST_PAYLOAD: begin
          push(cfsr_pkg::K_PAYLOAD, b, '0, '0, '0);
          crc_run = crc32_step(crc_run, b);
          bytes_done = bytes_done + 64'd1;
          chunk_left = chunk_left - 23'd1;
          if (chunk_left == 23'd0) begin
            ok = ((crc_run ^ 32'hFFFFFFFF) == crc_want);
            push(cfsr_pkg::K_ACK, '0, chunk_seq, ok, '0);
            if (!ok) begin
              push(cfsr_pkg::K_ERROR, '0, '0, '0, cfsr_pkg::E_CRC); state = ST_QUIET;
            end else begin
              next_seq = next_seq + 32'd1;
              if (bytes_done >= total_bytes) begin
                push(cfsr_pkg::K_DONE, '0, '0, '0, '0); state = ST_QUIET;
              end else begin
                state = ST_CHDR; field_cnt = '0; fault = '0;
              end
            end
          end
        end
        default: ;
      endcase
      if (pending.size() > prev_count) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(cfsr_pkg::result_t got);
      cfsr_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d data=%h seq=%h ok=%b code=%0d last=%b",
                 $time, got.kind, got.data_byte, got.ack_seq, got.ack_ok, got.error_code,
                 got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch exp kind=%0d data=%h seq=%h ok=%b code=%0d last=%b", $time,
                 want.kind, want.data_byte, want.ack_seq, want.ack_ok, want.error_code,
                 want.last);
        $display("%0t:          act kind=%0d data=%h seq=%h ok=%b code=%0d last=%b", $time,
                 got.kind, got.data_byte, got.ack_seq, got.ack_ok, got.error_code, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          cycle = 0;
  int          sent = 0;

  cfsr_byte_if   in_if ();
  cfsr_result_if out_if ();

  chunked_file_stream_receiver dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  receiver_scoreboard sb = new();
  logic [7:0] stream[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni && in_if.valid && in_if.ready) sb.note_byte(in_if.rx_byte);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.res);
  end

  // long receiver hold-off early on, then a calm stretch
  always @(posedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else if (cycle >= 150 && cycle < 350) out_if.ready <= 1'b0;
    else if (cycle >= 400 && cycle < 550) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(99) >= 15);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_byte(logic [7:0] b);
    if (!(sent >= 100 && sent < 160) && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending.size() != 0 || out_if.valid) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void put32(logic [31:0] w);
    for (int i = 3; i >= 0; i--) stream.push_back(w[i*8 +: 8]);
  endfunction

  initial begin
    logic [31:0] magic, version, chunk_sz, total, left, sz, crc, seq;
    logic [15:0] name_bytes;
    logic [7:0]  chunk_data[$];
    int          ending, hdr_len;

    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(cfsr_pkg::REG_MAGIC, 32'h0);
    write_reg(cfsr_pkg::REG_MAGIC, 32'hFFFFFFFF);
    write_reg(cfsr_pkg::REG_VERSION, 32'h0);
    write_reg(cfsr_pkg::REG_VERSION, 32'hFFFFFFFF);
    write_reg(cfsr_pkg::REG_NAME_LEN, 32'd1);
    write_reg(cfsr_pkg::REG_CHUNK, 32'd1);
    write_reg(cfsr_pkg::REG_CHUNK, 32'd4194304);

    magic = $urandom;
    version = $urandom;
    name_bytes = 16'($urandom_range(1, 6));
    chunk_sz = $urandom_range(20, 40);
    total = $urandom_range(90, 120);
    ending = $urandom_range(0, 9);
    write_reg(cfsr_pkg::REG_MAGIC, magic);
    write_reg(cfsr_pkg::REG_VERSION, version);
    write_reg(cfsr_pkg::REG_NAME_LEN, $urandom_range(1) ? 32'd65535 : {16'd0, name_bytes});
    write_reg(cfsr_pkg::REG_CHUNK, $urandom_range(1) ? 32'd4194304 : chunk_sz);

    put32(magic);
    put32(version);
    put32({16'd0, name_bytes});
    put32(32'd0);
    put32(total);
    put32(chunk_sz);
    for (int i = 0; i < name_bytes; i++) stream.push_back(8'($urandom));
    hdr_len = stream.size();

    seq = 0;
    left = total;
    while (left != 0) begin
      sz = $urandom_range(1, chunk_sz);
      if (sz > left) sz = left;
      left = left - sz;
      chunk_data = {};
      crc = 32'hFFFFFFFF;
      for (int i = 0; i < sz; i++) begin
        chunk_data.push_back(8'($urandom));
        crc = crc32_step(crc, chunk_data[i]);
      end
      crc = crc ^ 32'hFFFFFFFF;
      if (left == 0 && ending == 0) crc = crc ^ (32'd1 << $urandom_range(31));
      put32((left == 0 && ending == 1) ? seq + 32'd1 : seq);
      put32(sz);
      put32(crc);
      foreach (chunk_data[i]) stream.push_back(chunk_data[i]);
      seq++;
    end
    repeat (16) stream.push_back(8'($urandom));

    for (int i = 0; i < hdr_len; i++) send_byte(stream[i]);
    in_if.valid <= 1'b0;
    wait_idle();
    write_reg(cfsr_pkg::REG_VERSION, version);
    for (int i = hdr_len; i < stream.size(); i++) send_byte(stream[i]);
    in_if.valid <= 1'b0;
    wait_idle();
    repeat (16) @(posedge clk_i);

    for (int i = 0; i < sb.pending.size(); i++) begin
      $display("%0t: missing result kind=%0d", $time, sb.pending[i].kind);
      sb.errors++;
    end
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/cfsr_pkg.sv
sv/cfsr_stream_if.sv
sv/cfsr_front.sv
sv/cfsr_back.sv
sv/chunked_file_stream_receiver.sv
verif/chunked_file_stream_receiver_tb.sv
